// File: rtl/rbc_pkg.sv
`default_nettype none
package rbc_pkg;

  // Table entries are Q0.15 magnitudes, never negative.
  localparam int unsigned SINE_W = 15;
  localparam logic [SINE_W-1:0] SINE_MAX = 15'h7FFF;

  // pi/2 in Q30, the argument scale of the table build.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Divisors of the Taylor terms: (2n)(2n+1) for n = 1..8.
  localparam logic [63:0] TAYLOR_DIV [8] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
  };

  localparam int unsigned POS_W      = 16;
  localparam int unsigned TURN_W     = 16;
  localparam int unsigned SIZE_W     = 10;
  localparam int unsigned OFS_W      = 10;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned TRIG_W     = 16;  // signed sine or cosine
  localparam int unsigned PROD_W     = 26;  // half size times sine or cosine
  localparam int unsigned ROT_W      = 27;  // sum of two products
  localparam int unsigned CTR_W      = 19;  // centre in half pixels

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_WIDTH  = 4'd0,
    CFG_BOX_HEIGHT = 4'd1,
    CFG_OFFSET_X   = 4'd2,
    CFG_OFFSET_Y   = 4'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // The four distinct products; every corner is a signed mix of them.
  typedef struct packed {
    logic signed [PROD_W-1:0] w_cos;
    logic signed [PROD_W-1:0] h_sin;
    logic signed [PROD_W-1:0] w_sin;
    logic signed [PROD_W-1:0] h_cos;
  } rot_prod_t;

  // Sine from a Q30 argument: 9-term Taylor series, rounded to Q15.
  function automatic logic [SINE_W-1:0] sine_q15(input logic [63:0] x);
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    term = x;
    sum  = signed'(x);
    for (int n = 0; n < 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n[2:0]];
      if ((n % 2) == 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    r = (unsigned'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/rotated_box_corners_core.sv
`default_nettype none
// Corners of a rotated rectangle.
//
// Input channel: drive pos_x_i, pos_y_i and turn_i with start_i high; the
// word is taken at the rising edge where start_i is high and busy_o is low.
// busy_o stays low: the pipeline takes one word in every cycle.
// Result channel: valid_o is high for exactly one cycle with all four
// corners on the result ports; the receiver cannot stall, so take the word
// in that cycle. Results come back in order.
// From the accepting edge the word passes the input register, the sine table
// read, the product register and the result register. Throughput: one word per
// cycle, set by the single-pass pipeline.
// Configuration: cfg_valid_i/cfg_ready_o write box_width, box_height,
// offset_x, offset_y by index; cfg_ready_o is always high, unknown indexes
// drop. Write only while no word is in flight.
// Reset (rst_ni low, asynchronous) empties the pipeline and restores the
// size to 32 by 32 and the offsets to zero.
module rotated_box_corners_core
  import rbc_pkg::*;
#(
  parameter int unsigned ANGLE_BITS       = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic [TURN_W-1:0]      turn_i,
  output logic                        valid_o,
  output logic signed [POS_W-1:0]     top_left_x_o,
  output logic signed [POS_W-1:0]     top_left_y_o,
  output logic signed [POS_W-1:0]     top_right_x_o,
  output logic signed [POS_W-1:0]     top_right_y_o,
  output logic signed [POS_W-1:0]     bottom_left_x_o,
  output logic signed [POS_W-1:0]     bottom_left_y_o,
  output logic signed [POS_W-1:0]     bottom_right_x_o,
  output logic signed [POS_W-1:0]     bottom_right_y_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned QW     = ANGLE_BITS - 2;
  localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IDX_PW = QW + ADDR_W;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SIZE_W-1:0]        box_width_q, box_height_q;
  logic signed [OFS_W-1:0]  offset_x_q, offset_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_width_q  <= SIZE_W'(32);
      box_height_q <= SIZE_W'(32);
      offset_x_q   <= '0;
      offset_y_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BOX_WIDTH:  box_width_q  <= cfg_data_i;
        CFG_BOX_HEIGHT: box_height_q <= cfg_data_i;
        CFG_OFFSET_X:   offset_x_q   <= signed'(cfg_data_i);
        CFG_OFFSET_Y:   offset_y_q   <= signed'(cfg_data_i);
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------
  logic                     accept;
  logic                     s0_valid_q;
  logic signed [POS_W-1:0]  s0_pos_x_q, s0_pos_y_q;
  logic [TURN_W-1:0]        s0_turn_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_pos_x_q <= pos_x_i;
      s0_pos_y_q <= pos_y_i;
      s0_turn_q  <= turn_i;
    end
  end

  // Split the angle into quadrant and table index.
  logic [ANGLE_BITS-1:0] phase;
  quad_e                 s0_quad;
  logic [IDX_PW-1:0]     idx_prod;
  logic [ADDR_W-1:0]     rom_addr_a, rom_addr_b;
  logic [SINE_W-1:0]     tab_a, tab_b;

  assign phase      = ANGLE_BITS'(s0_turn_q);
  assign s0_quad    = quad_e'(phase[ANGLE_BITS-1 -: 2]);
  assign idx_prod   = IDX_PW'(phase[QW-1:0]) * IDX_PW'(SINE_TABLE_DEPTH);
  assign rom_addr_a = ADDR_W'(idx_prod >> QW);
  assign rom_addr_b = ADDR_W'(SINE_TABLE_DEPTH) - rom_addr_a;

  rbc_sine_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_sine_rom (
    .clk_i    (clk_i),
    .addr_a_i (rom_addr_a),
    .addr_b_i (rom_addr_b),
    .data_a_o (tab_a),
    .data_b_o (tab_b)
  );

  // ---------------------------------------------------------------------
  // Stage 1: table data, quadrant and centre in half pixels
  // ---------------------------------------------------------------------
  logic                     s1_valid_q;
  quad_e                    s1_quad_q;
  logic signed [CTR_W-1:0]  s1_ctr2_x_q, s1_ctr2_y_q;
  logic signed [CTR_W-1:0]  ctr2_x_d, ctr2_y_d;
  logic signed [POS_W:0]    base_x, base_y;

  always_comb begin
    base_x   = (POS_W + 1)'(s0_pos_x_q) + (POS_W + 1)'(offset_x_q);
    base_y   = (POS_W + 1)'(s0_pos_y_q) + (POS_W + 1)'(offset_y_q);
    ctr2_x_d = {base_x[POS_W], base_x, 1'b0} + CTR_W'({1'b0, box_width_q});
    ctr2_y_d = {base_y[POS_W], base_y, 1'b0} + CTR_W'({1'b0, box_height_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_quad_q   <= s0_quad;
    s1_ctr2_x_q <= ctr2_x_d;
    s1_ctr2_y_q <= ctr2_y_d;
  end

  // ---------------------------------------------------------------------
  // Stage 2: products of half size and sine/cosine
  // ---------------------------------------------------------------------
  rot_prod_t                s2_prod;
  logic                     s2_valid_q;
  logic signed [CTR_W-1:0]  s2_ctr2_x_q, s2_ctr2_y_q;

  rbc_rotate u_rotate (
    .clk_i    (clk_i),
    .quad_i   (s1_quad_q),
    .tab_a_i  (tab_a),
    .tab_b_i  (tab_b),
    .half_w_i (box_width_q[SIZE_W-1:1]),
    .half_h_i (box_height_q[SIZE_W-1:1]),
    .prod_o   (s2_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ctr2_x_q <= s1_ctr2_x_q;
    s2_ctr2_y_q <= s1_ctr2_y_q;
  end

  // ---------------------------------------------------------------------
  // Stage 3: mix products per corner, add centre, saturate, register
  // Corner vector (vx, vy) rotates to (vx*cos - vy*sin, vx*sin + vy*cos).
  // ---------------------------------------------------------------------
  logic signed [ROT_W-1:0] wc, hs, ws, hc;
  logic signed [ROT_W-1:0] tl_rx, tl_ry, tr_rx, tr_ry;
  logic signed [ROT_W-1:0] bl_rx, bl_ry, br_rx, br_ry;
  logic signed [POS_W-1:0] tl_x_d, tl_y_d, tr_x_d, tr_y_d;
  logic signed [POS_W-1:0] bl_x_d, bl_y_d, br_x_d, br_y_d;
  logic                    valid_q;

  assign wc = ROT_W'(s2_prod.w_cos);
  assign hs = ROT_W'(s2_prod.h_sin);
  assign ws = ROT_W'(s2_prod.w_sin);
  assign hc = ROT_W'(s2_prod.h_cos);

  assign tl_rx = -wc + hs;   // (-w/2, -h/2)
  assign tl_ry = -ws - hc;
  assign tr_rx =  wc + hs;   // (+w/2, -h/2)
  assign tr_ry =  ws - hc;
  assign bl_rx = -wc - hs;   // (-w/2, +h/2)
  assign bl_ry = -ws + hc;
  assign br_rx =  wc - hs;   // (+w/2, +h/2)
  assign br_ry =  ws + hc;

  rbc_corner u_tl_x (.rot_i(tl_rx), .ctr2_i(s2_ctr2_x_q), .coord_o(tl_x_d));
  rbc_corner u_tl_y (.rot_i(tl_ry), .ctr2_i(s2_ctr2_y_q), .coord_o(tl_y_d));
  rbc_corner u_tr_x (.rot_i(tr_rx), .ctr2_i(s2_ctr2_x_q), .coord_o(tr_x_d));
  rbc_corner u_tr_y (.rot_i(tr_ry), .ctr2_i(s2_ctr2_y_q), .coord_o(tr_y_d));
  rbc_corner u_bl_x (.rot_i(bl_rx), .ctr2_i(s2_ctr2_x_q), .coord_o(bl_x_d));
  rbc_corner u_bl_y (.rot_i(bl_ry), .ctr2_i(s2_ctr2_y_q), .coord_o(bl_y_d));
  rbc_corner u_br_x (.rot_i(br_rx), .ctr2_i(s2_ctr2_x_q), .coord_o(br_x_d));
  rbc_corner u_br_y (.rot_i(br_ry), .ctr2_i(s2_ctr2_y_q), .coord_o(br_y_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    top_left_x_o     <= tl_x_d;
    top_left_y_o     <= tl_y_d;
    top_right_x_o    <= tr_x_d;
    top_right_y_o    <= tr_y_d;
    bottom_left_x_o  <= bl_x_d;
    bottom_left_y_o  <= bl_y_d;
    bottom_right_x_o <= br_x_d;
    bottom_right_y_o <= br_y_d;
  end

  assign valid_o = valid_q;

`ifndef SYNTH
  // Every accepted word produces a result on valid_o.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 valid_o)
    else $error("accepted word did not produce a result");

  // No result appears without an accepted word.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 4))
    else $error("result without an accepted word");

  // Angle zero of a quadrant reads sine zero.
  a_tab_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && rom_addr_a == '0) |=> (tab_a == '0))
    else $error("sine table entry zero is not zero");

  // The quarter-wave end reads full scale.
  a_tab_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && rom_addr_b == ADDR_W'(SINE_TABLE_DEPTH)) |=> (tab_b == SINE_MAX))
    else $error("sine table end entry is not full scale");
`endif

endmodule
`default_nettype wire

// File: rtl/rbc_sine_rom.sv
`default_nettype none
module rbc_sine_rom
  import rbc_pkg::*;
#(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned ADDR_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic [ADDR_W-1:0] addr_a_i,
  input  wire logic [ADDR_W-1:0] addr_b_i,
  output logic      [SINE_W-1:0] data_a_o,
  output logic      [SINE_W-1:0] data_b_o
);

  logic [SINE_W-1:0] rom_tbl [DEPTH+1];

  // Quarter wave, entry k = sin(pi/2 * k / DEPTH), built at elaboration.
  for (genvar k = 0; k <= DEPTH; k++) begin : g_entry
    localparam logic [63:0] ArgQ30 = (64'(k) * HALF_PI_Q30) / DEPTH;
    assign rom_tbl[k] = sine_q15(ArgQ30);
  end

  always_ff @(posedge clk_i) begin
    data_a_o <= rom_tbl[addr_a_i];
    data_b_o <= rom_tbl[addr_b_i];
  end

endmodule
`default_nettype wire

// File: rtl/rbc_rotate.sv
`default_nettype none
module rbc_rotate
  import rbc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire quad_e             quad_i,
  input  wire logic [SINE_W-1:0] tab_a_i,   // T[idx]
  input  wire logic [SINE_W-1:0] tab_b_i,   // T[depth-idx]
  input  wire logic [SIZE_W-2:0] half_w_i,
  input  wire logic [SIZE_W-2:0] half_h_i,
  output rot_prod_t              prod_o
);

  logic signed [TRIG_W-1:0] pos_a, pos_b, neg_a, neg_b;
  logic signed [TRIG_W-1:0] sin_v, cos_v;
  logic signed [SIZE_W-1:0] hw_s, hh_s;
  rot_prod_t                prod_d;

  assign pos_a = signed'({1'b0, tab_a_i});
  assign pos_b = signed'({1'b0, tab_b_i});
  assign neg_a = -pos_a;
  assign neg_b = -pos_b;
  assign hw_s  = signed'({1'b0, half_w_i});
  assign hh_s  = signed'({1'b0, half_h_i});

  // Fold the quarter-wave entries out to the full circle.
  always_comb begin
    unique case (quad_i)
      QUAD_0: begin
        sin_v = pos_a; cos_v = pos_b;
      end
      QUAD_1: begin
        sin_v = pos_b; cos_v = neg_a;
      end
      QUAD_2: begin
        sin_v = neg_a; cos_v = neg_b;
      end
      default: begin
        sin_v = neg_b; cos_v = pos_a;
      end
    endcase
  end

  always_comb begin
    prod_d.w_cos = PROD_W'(hw_s * cos_v);
    prod_d.h_sin = PROD_W'(hh_s * sin_v);
    prod_d.w_sin = PROD_W'(hw_s * sin_v);
    prod_d.h_cos = PROD_W'(hh_s * cos_v);
  end

  always_ff @(posedge clk_i) begin
    prod_o <= prod_d;
  end

endmodule
`default_nettype wire

// File: rtl/rbc_corner.sv
`default_nettype none
module rbc_corner
  import rbc_pkg::*;
(
  input  wire logic signed [ROT_W-1:0] rot_i,   // rotated component, Q15
  input  wire logic signed [CTR_W-1:0] ctr2_i,  // centre, half pixels
  output logic signed      [POS_W-1:0] coord_o
);

  logic signed [ROT_W-1:0] biased;
  logic signed [ROT_W-1:0] shifted;
  logic signed [11:0]      rot_px;
  logic signed [20:0]      sum2;
  logic signed [20:0]      adj;
  logic signed [20:0]      half;

  always_comb begin
    // Truncate toward zero: bias negatives before the arithmetic shift.
    biased  = rot_i + (rot_i[ROT_W-1] ? ROT_W'(32767) : ROT_W'(0));
    shifted = biased >>> 15;
    rot_px  = 12'(shifted);
    sum2    = {{8{rot_px[11]}}, rot_px, 1'b0} + {{2{ctr2_i[CTR_W-1]}}, ctr2_i};
    // Halve toward zero.
    adj     = sum2 + {20'd0, sum2[20]};
    half    = adj >>> 1;
    if (half > 21'sd32767) begin
      coord_o = 16'sh7FFF;
    end else if (half < -21'sd32768) begin
      coord_o = 16'sh8000;
    end else begin
      coord_o = 16'(half);
    end
  end

endmodule
`default_nettype wire
